@@ hw/rtl/fpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed partition fit allocator package
// Shared constants, codes and the cell control type.
// ----------------------------------------------------------------------------
`default_nettype none

package fpfa_pkg;

    localparam int NUM_PARTITIONS_DEF = 8;
    localparam int SIZE_WIDTH_DEF     = 16;

    localparam int FIELD_SLOT_W = 3;
    localparam int FIELD_SIZE_W = 16;
    localparam int STATUS_W     = 2;
    localparam int POLICY_W     = 2;
    localparam int PIU_W        = 4;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 4;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 24;
    localparam int PIU_RESET    = 8;

    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_LOADED      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ALLOCATED   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNALLOCATED = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_FIT_POLICY   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PARTS_IN_USE = 1'd1;

    typedef struct packed {
        logic                load;
        logic                grant;
        logic [POLICY_W-1:0] policy;
    } fpfa_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/fpfa_cell.sv @@
// ----------------------------------------------------------------------------
// Fixed partition fit allocator cell
// Holds one partition's size and allocated mark and refines the search
// candidate that passes through it, one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpfa_cell
    import fpfa_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 3,
    parameter int STORE_W    = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire fpfa_ctl_t          ctl,
    input  wire logic [IDX_W-1:0]   target,
    input  wire logic [STORE_W-1:0] load_size,
    input  wire logic [STORE_W-1:0] req_size,
    input  wire logic [PIU_W-1:0]   parts_in_use,
    input  wire logic               in_valid,
    input  wire logic               in_found,
    input  wire logic [IDX_W-1:0]   in_pick,
    input  wire logic [STORE_W-1:0] in_size,
    output logic                    out_valid,
    output logic                    out_found,
    output logic [IDX_W-1:0]        out_pick,
    output logic [STORE_W-1:0]      out_size
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
    localparam logic [6:0]       MY_IDX7 = 7'(CELL_INDEX);

    logic [STORE_W-1:0] size_reg;
    logic               alloc_reg;
    logic               valid_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   pick_reg;
    logic [STORE_W-1:0] psize_reg;

    logic               enabled;
    logic               fits;
    logic               take;

    assign enabled = MY_IDX7 < {3'b000, parts_in_use};
    assign fits    = enabled && !alloc_reg && (size_reg >= req_size);

    always_comb begin
        take = 1'b0;
        if (fits) begin
            if (!in_found) begin
                take = 1'b1;
            end else begin
                case (ctl.policy)
                    POLICY_BEST: begin
                        take = size_reg < in_size;
                    end
                    POLICY_WORST: begin
                        take = size_reg > in_size;
                    end
                    default: begin
                        take = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= '0;
            alloc_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
            if (ctl.load && target == MY_IDX) begin
                size_reg  <= load_size;
                alloc_reg <= 1'b0;
            end else if (ctl.grant && target == MY_IDX) begin
                alloc_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            found_reg <= 1'b1;
            pick_reg  <= MY_IDX;
            psize_reg <= size_reg;
        end else begin
            found_reg <= in_found;
            pick_reg  <= in_pick;
            psize_reg <= in_size;
        end
    end

    assign out_valid = valid_reg;
    assign out_found = found_reg;
    assign out_pick  = pick_reg;
    assign out_size  = psize_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fixed_partition_fit_allocator.sv @@
// ----------------------------------------------------------------------------
// Fixed partition fit allocator
// Keeps partition sizes and allocated marks in a row of cells and grants
// free partitions by first, best or worst fit.
// ----------------------------------------------------------------------------
// Input beats carry the operation in s_tuser and the slot and size in
// s_tdata. A load writes one partition's size and frees it. A request
// sends a search candidate down the cell row; each cell compares its own
// partition with the candidate and hands the result to its neighbor on the
// next clock.
// A load beat goes from the idle state through the done state into the
// output register; a request beat is injected into the cell row, scanned
// in the scan state and then passes through the done state into the
// output register. One item is worked on at a time; the next beat is
// accepted once the previous result has moved into the output register.
// When the receiver stalls, the result stays in the output register and
// the block finishes at most one more item before it holds s_tready low.
// Reset clears all partition sizes and marks, sets first fit and eight
// partitions in use. Configuration writes take effect at once; the user
// must make them only while no item is in flight (the block does not check).
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_partition_fit_allocator
    import fpfa_pkg::*;
#(
    parameter int NUM_PARTITIONS = NUM_PARTITIONS_DEF,
    parameter int SIZE_WIDTH     = SIZE_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // Bits from low: slot_index [2:0], size_value [18:3], zero [23:19].
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // Bits from low: operation [0].
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // Bits from low: chosen_slot [2:0], chosen_size [18:3], zero [23:19].
    output logic [M_TDATA_W-1:0]       m_tdata,
    // Bits from low: status [1:0].
    output logic [STATUS_W-1:0]        m_tuser
);

    localparam int IDX_W   = $clog2(NUM_PARTITIONS);
    localparam int STORE_W = (SIZE_WIDTH < FIELD_SIZE_W) ? SIZE_WIDTH : FIELD_SIZE_W;
    localparam logic [6:0] NUM7 = 7'(NUM_PARTITIONS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [POLICY_W-1:0]      policy_reg;
    logic [PIU_W-1:0]         piu_reg;
    logic [STORE_W-1:0]       req_size_reg;
    logic                     inj_valid_reg;
    logic [STATUS_W-1:0]      res_status_reg;
    logic [FIELD_SLOT_W-1:0]  res_slot_reg;
    logic [FIELD_SIZE_W-1:0]  res_size_reg;
    logic                     m_tvalid_reg;
    logic [STATUS_W-1:0]      m_status_reg;
    logic [FIELD_SLOT_W-1:0]  m_slot_reg;
    logic [FIELD_SIZE_W-1:0]  m_size_reg;

    logic                     s_accept;
    logic [FIELD_SLOT_W-1:0]  in_slot;
    logic [STORE_W-1:0]       in_size;
    logic                     load_hit;
    logic                     scan_done;
    logic                     out_free;
    fpfa_ctl_t                ctl;
    logic [IDX_W-1:0]         target;

    logic [NUM_PARTITIONS:0]  chain_valid;
    logic [NUM_PARTITIONS:0]  chain_found;
    logic [IDX_W-1:0]         chain_pick [NUM_PARTITIONS+1];
    logic [STORE_W-1:0]       chain_size [NUM_PARTITIONS+1];

    assign s_tready  = state_reg == ST_IDLE;
    assign s_accept  = s_tvalid && s_tready;
    assign in_slot   = s_tdata[FIELD_SLOT_W-1:0];
    assign in_size   = s_tdata[FIELD_SLOT_W +: STORE_W];
    assign load_hit  = {4'b0000, in_slot} < NUM7;
    assign scan_done = (state_reg == ST_SCAN) && chain_valid[NUM_PARTITIONS];
    assign out_free  = !m_tvalid_reg || m_tready;

    assign ctl.load   = s_accept && (s_tuser == OP_LOAD) && load_hit;
    assign ctl.grant  = scan_done && chain_found[NUM_PARTITIONS];
    assign ctl.policy = policy_reg;
    assign target     = (state_reg == ST_SCAN) ? chain_pick[NUM_PARTITIONS]
                                               : IDX_W'(in_slot);

    assign chain_valid[0] = inj_valid_reg;
    assign chain_found[0] = 1'b0;
    assign chain_pick[0]  = '0;
    assign chain_size[0]  = '0;

    for (genvar k = 0; k < NUM_PARTITIONS; k++) begin : g_cell
        fpfa_cell #(
            .CELL_INDEX (k),
            .IDX_W      (IDX_W),
            .STORE_W    (STORE_W)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl          (ctl),
            .target       (target),
            .load_size    (in_size),
            .req_size     (req_size_reg),
            .parts_in_use (piu_reg),
            .in_valid     (chain_valid[k]),
            .in_found     (chain_found[k]),
            .in_pick      (chain_pick[k]),
            .in_size      (chain_size[k]),
            .out_valid    (chain_valid[k+1]),
            .out_found    (chain_found[k+1]),
            .out_pick     (chain_pick[k+1]),
            .out_size     (chain_size[k+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser == OP_LOAD) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            policy_reg    <= POLICY_FIRST;
            piu_reg       <= PIU_W'(PIU_RESET);
            inj_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            inj_valid_reg <= s_accept && (s_tuser == OP_REQUEST);
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_FIT_POLICY: begin
                        policy_reg <= cfg_wdata[POLICY_W-1:0];
                    end
                    REG_PARTS_IN_USE: begin
                        piu_reg <= cfg_wdata[PIU_W-1:0];
                    end
                    default: begin
                        piu_reg <= piu_reg;
                    end
                endcase
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_size_reg   <= in_size;
            res_status_reg <= STAT_LOADED;
            res_slot_reg   <= in_slot;
            res_size_reg   <= load_hit ? FIELD_SIZE_W'(in_size) : '0;
        end else if (scan_done) begin
            if (chain_found[NUM_PARTITIONS]) begin
                res_status_reg <= STAT_ALLOCATED;
                res_slot_reg   <= FIELD_SLOT_W'(chain_pick[NUM_PARTITIONS]);
                res_size_reg   <= FIELD_SIZE_W'(chain_size[NUM_PARTITIONS]);
            end else begin
                res_status_reg <= STAT_UNALLOCATED;
                res_slot_reg   <= '0;
                res_size_reg   <= '0;
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_size_reg   <= res_size_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W - FIELD_SLOT_W - FIELD_SIZE_W){1'b0}},
                       m_size_reg, m_slot_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(chain_valid))
        else $error("More than one search candidate in the cell row.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.grant |-> (state_reg == ST_SCAN) && !ctl.load)
        else $error("Grant outside a finished scan.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("Result beat without a finished item.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        inj_valid_reg |-> state_reg == ST_SCAN)
        else $error("Search started outside the scan state.");

endmodule

`default_nettype wire
